@@ design/lightfield_shift_sum_accumulator_macros.svh @@
// ---------------------------------------------------------------------------
// lightfield shift-sum accumulator assertion macros
// shared property forms for the accumulator's concurrent checks
// ---------------------------------------------------------------------------
`ifndef LIGHTFIELD_SHIFT_SUM_ACCUMULATOR_MACROS_SVH
`define LIGHTFIELD_SHIFT_SUM_ACCUMULATOR_MACROS_SVH

// same-cycle implication under reset
`define LFSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define LFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lfss_pkg.sv @@
// ---------------------------------------------------------------------------
// lfss_pkg
// shared types, sizes and codes of the shift-sum accumulator
// ---------------------------------------------------------------------------
package lfss_pkg;

	// tile geometry
	localparam int TILE_ROWS     = 8;
	localparam int TILE_COLS     = 256;
	localparam int MAX_APERTURES = 255;

	// field sizes
	localparam int SLOT_W     = 11;
	localparam int SLOT_DEPTH = 1 << SLOT_W;
	localparam int CHAN_W     = 8;
	localparam int NUM_CH     = 3;
	localparam int NUM_TAPS   = 4;
	localparam int RGB_W      = CHAN_W * NUM_CH;
	localparam int Q_BITS     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int PROD_W     = CHAN_W + WEIGHT_W;
	localparam int TERM_W     = PROD_W - Q_BITS;
	localparam int TSUM_W     = TERM_W + $clog2(NUM_TAPS);
	localparam int SUM_W      = 16;
	localparam int COUNT_W    = 8;
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int CFG_IDX_W  = 2;

	// slots at or above this limit are outside the tile
	localparam int SLOT_LIMIT_I = (TILE_ROWS * TILE_COLS < SLOT_DEPTH) ?
		TILE_ROWS * TILE_COLS : SLOT_DEPTH;
	localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_LIMIT_I);

	localparam logic [CHAN_W-1:0]  CHAN_MAX  = {CHAN_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [NUM_TAPS-1:0][CHAN_W-1:0]   samples_t;
	typedef logic [NUM_TAPS-1:0][WEIGHT_W-1:0] weights_t;

	// one accumulator entry
	typedef struct packed {
		count_t                         count;
		logic [NUM_CH-1:0][SUM_W-1:0]   sums;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	// request codes
	typedef enum logic {
		CMD_ACCUM = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// weight register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_TL = 2'd0,
		REG_WEIGHT_TR = 2'd1,
		REG_WEIGHT_BL = 2'd2,
		REG_WEIGHT_BR = 2'd3
	} cfg_idx_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MEM,
		ST_DIV,
		ST_FIN
	} state_t;

	// per-lane control from the sequencer
	typedef struct packed {
		logic mul_en;
		logic div_load;
		logic div_step;
	} lane_ctrl_t;

endpackage

@@ design/lightfield_shift_sum_accumulator.sv @@
// ---------------------------------------------------------------------------
// lightfield_shift_sum_accumulator
// tile accumulator for shift-and-sum refocus with averaged readout
// ---------------------------------------------------------------------------
// After reset the block sweeps its 2048-entry accumulator to zero, one entry
// a cycle, and holds busy high through the sweep; weight writes are
// taken during the sweep. An accumulate request keeps busy high in the
// cycle after it is taken (the read-modify-write of the slot in the
// accumulator memory), so no new request is taken until that write is done.
// A readout of an uncovered or out-of-tile slot also passes through ST_MEM,
// with the result strobed on done in the first cycle that busy is low again.
// A readout of a covered slot runs the three channel dividers for 16 steps,
// one quotient bit a cycle, and keeps busy high through ST_MEM, ST_DIV and
// ST_FIN. The result is shown on done for a single cycle and cannot be held
// off; it must be captured at that edge.
module lightfield_shift_sum_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  lfss_pkg::slot_t              pixel_slot,
	input  logic [lfss_pkg::RGB_W-1:0]   top_left_rgb,
	input  logic [lfss_pkg::RGB_W-1:0]   top_right_rgb,
	input  logic [lfss_pkg::RGB_W-1:0]   bottom_left_rgb,
	input  logic [lfss_pkg::RGB_W-1:0]   bottom_right_rgb,
	// weight register writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lfss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  lfss_pkg::weight_t            cfg_wdata,
	// result
	output logic                         done,
	output lfss_pkg::slot_t              slot_out,
	output lfss_pkg::chan_t              red_out,
	output lfss_pkg::chan_t              green_out,
	output lfss_pkg::chan_t              blue_out,
	output logic                         covered
);
	import lfss_pkg::*;

	state_t     state_q, state_d;
	slot_t      clr_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	weights_t   weights_q;
	logic       cmd_q;
	slot_t      slot_q;
	logic       slot_ok_q;
	count_t     count_q;
	logic       accept;
	lane_ctrl_t lane_ctrl;

	slot_word_t rd_word;
	slot_word_t wr_word;
	logic       ram_we;
	slot_t      ram_waddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [NUM_CH-1:0][SUM_W-1:0]  new_sums;
	logic [NUM_CH-1:0][CHAN_W-1:0] avgs;
	count_t     count_inc;

	logic       done_q;
	slot_t      slot_out_q;
	chan_t      red_q, green_q, blue_q;
	logic       covered_q;
	logic       out_load_zero;
	logic       out_load_avg;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_WEIGHT_TL: weights_q[0] <= cfg_wdata;
				REG_WEIGHT_TR: weights_q[1] <= cfg_wdata;
				REG_WEIGHT_BL: weights_q[2] <= cfg_wdata;
				REG_WEIGHT_BR: weights_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			slot_q    <= pixel_slot;
			slot_ok_q <= ({1'b0, pixel_slot} < SLOT_LIMIT);
		end
	end

	// accumulator memory
	assign rd_word = slot_word_t'(ram_rdata);

	lfss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOT_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_word),
		.raddr (pixel_slot),
		.rdata (ram_rdata)
	);

	// channel lanes
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		samples_t lane_samples;

		assign lane_samples[0] = top_left_rgb[c*CHAN_W +: CHAN_W];
		assign lane_samples[1] = top_right_rgb[c*CHAN_W +: CHAN_W];
		assign lane_samples[2] = bottom_left_rgb[c*CHAN_W +: CHAN_W];
		assign lane_samples[3] = bottom_right_rgb[c*CHAN_W +: CHAN_W];

		lfss_lane u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.samples (lane_samples),
			.weights (weights_q),
			.old_sum (rd_word.sums[c]),
			.divisor (count_q),
			.new_sum (new_sums[c]),
			.avg     (avgs[c])
		);
	end

	assign count_inc = (rd_word.count == COUNT_MAX) ? rd_word.count :
		rd_word.count + count_t'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory write and lane control
	always_comb begin
		state_d            = state_q;
		busy               = 1'b1;
		ram_we             = 1'b0;
		ram_waddr          = slot_q;
		wr_word            = '0;
		lane_ctrl          = '0;
		out_load_zero      = 1'b0;
		out_load_avg       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				if (clr_cnt_q == slot_t'(SLOT_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy             = 1'b0;
				lane_ctrl.mul_en = start;
				if (start) begin
					state_d = ST_MEM;
				end
			end
			ST_MEM: begin
				state_d = ST_IDLE;
				if (cmd_q == CMD_ACCUM) begin
					ram_we        = slot_ok_q;
					wr_word.sums  = new_sums;
					wr_word.count = count_inc;
				end else begin
					ram_we = slot_ok_q;
					if (!slot_ok_q || rd_word.count == '0) begin
						out_load_zero = 1'b1;
					end else begin
						lane_ctrl.div_load = 1'b1;
						state_d            = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				lane_ctrl.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				out_load_avg = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sweep and divider step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + slot_t'(1);
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// divisor held for the divide
	always_ff @(posedge clk) begin
		if (lane_ctrl.div_load) begin
			count_q <= rd_word.count;
		end
	end

	// merge lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= out_load_zero || out_load_avg;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_zero) begin
			slot_out_q <= slot_q;
			red_q      <= '0;
			green_q    <= '0;
			blue_q     <= '0;
			covered_q  <= 1'b0;
		end else if (out_load_avg) begin
			slot_out_q <= slot_q;
			red_q      <= avgs[0];
			green_q    <= avgs[1];
			blue_q     <= avgs[2];
			covered_q  <= 1'b1;
		end
	end

	assign done      = done_q;
	assign slot_out  = slot_out_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign covered   = covered_q;

	// checks
`include "lightfield_shift_sum_accumulator_macros.svh"

	`LFSS_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept,
		busy && state_q == ST_MEM, "request taken but block not busy")
	`LFSS_ASSERT_NEXT(a_accum_no_result, clk, arst_n,
		state_q == ST_MEM && cmd_q == CMD_ACCUM, !done, "accumulate produced a result")
	`LFSS_ASSERT_NOW(a_done_when_idle, clk, arst_n, done, state_q == ST_IDLE,
		"result strobe outside idle")
	`LFSS_ASSERT_NOW(a_div_nonzero, clk, arst_n, state_q == ST_DIV, count_q != '0,
		"divide by zero count")

endmodule

@@ design/lfss_ram.sv @@
// ---------------------------------------------------------------------------
// lfss_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module lfss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/lfss_lane.sv @@
// ---------------------------------------------------------------------------
// lfss_lane
// one color channel: weighted tap terms, sum update and serial divider
// ---------------------------------------------------------------------------
module lfss_lane (
	input  logic                clk,
	input  lfss_pkg::lane_ctrl_t ctrl,
	input  lfss_pkg::samples_t  samples,
	input  lfss_pkg::weights_t  weights,
	input  lfss_pkg::sum_t      old_sum,
	input  lfss_pkg::count_t    divisor,
	output lfss_pkg::sum_t      new_sum,
	output lfss_pkg::chan_t     avg
);
	import lfss_pkg::*;

	logic [NUM_TAPS-1:0][TERM_W-1:0] term_s1;
	logic [NUM_TAPS-1:0][PROD_W-1:0] prod;
	logic [TSUM_W-1:0]               tsum;
	logic [COUNT_W-1:0]              rem_q;
	sum_t                            quo_q;
	logic [COUNT_W:0]                shifted;
	logic [COUNT_W:0]                diff;
	logic                            fits;

	// tap products, truncated to the integer part
	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			prod[i] = PROD_W'(samples[i]) * PROD_W'(weights[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				term_s1[i] <= prod[i][PROD_W-1:Q_BITS];
			end
		end
	end

	// wrapping sum update
	always_comb begin
		tsum = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			tsum = tsum + TSUM_W'(term_s1[i]);
		end
		new_sum = old_sum + SUM_W'(tsum);
	end

	// restoring divider, one quotient bit per step
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			quo_q <= old_sum;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
		end
	end

	// clamp the quotient to the channel range
	assign avg = (|quo_q[SUM_W-1:CHAN_W]) ? CHAN_MAX : quo_q[CHAN_W-1:0];

endmodule
